// ----- src/acr_pkg.sv -----
// ---------------------------------------------------------------------------
// acr_pkg
// Shared sizes, codes, controller types and the lfsr step for the
// associative cache with selectable replacement.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package acr_pkg;

    localparam int ENTRIES   = 16;
    localparam int DATA_W    = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int SLOT_W    = 4;
    localparam int STAMP_W   = 32;
    localparam int LFSR_W    = 16;
    localparam int POL_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'd1;

    // replacement policy codes (code three behaves as fifo)
    localparam logic [POL_W-1:0] POL_FIFO   = 2'd0;
    localparam logic [POL_W-1:0] POL_RANDOM = 2'd1;
    localparam logic [POL_W-1:0] POL_LRU    = 2'd2;

    // item kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_VREAD,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic pick;
        logic update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

    // galois step, shift right
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0]) begin
            nxt = nxt ^ LFSR_MASK;
        end
        return nxt;
    endfunction

    // a zero seed would lock the generator
    function automatic logic [LFSR_W-1:0] lfsr_load(input logic [LFSR_W-1:0] seed);
        logic [LFSR_W-1:0] val;
        val = (seed == '0) ? LFSR_W'(1) : seed;
        return val;
    endfunction

endpackage

// ----- src/acr_ctrl.sv -----
// ---------------------------------------------------------------------------
// acr_ctrl
// Sequencer for one item: scan the slots, pick the slot, read it back,
// update the stores and hand the result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  acr_pkg::t_dp_sts i_sts,
    output acr_pkg::t_dp_cmd o_cmd
);

    acr_pkg::t_state r_state;
    acr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            acr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = acr_pkg::ST_SCAN;
                end
            end
            acr_pkg::ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = acr_pkg::ST_DRAIN;
                end
            end
            // the check of the last slot lands here
            acr_pkg::ST_DRAIN:  n_state = acr_pkg::ST_PICK;
            acr_pkg::ST_PICK:   n_state = acr_pkg::ST_VREAD;
            acr_pkg::ST_VREAD:  n_state = acr_pkg::ST_UPDATE;
            acr_pkg::ST_UPDATE: n_state = acr_pkg::ST_DONE;
            acr_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = acr_pkg::ST_IDLE;
                end
            end
            default: n_state = acr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            acr_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            acr_pkg::ST_SCAN:   o_cmd.scan     = 1'b1;
            acr_pkg::ST_DRAIN:  o_cmd          = '0;
            acr_pkg::ST_PICK:   o_cmd.pick     = 1'b1;
            acr_pkg::ST_VREAD:  o_cmd          = '0;
            acr_pkg::ST_UPDATE: o_cmd.update   = 1'b1;
            acr_pkg::ST_DONE:   o_cmd.load_out = i_sts.out_free;
            default:            o_cmd          = '0;
        endcase
    end

endmodule

// ----- src/acr_dp.sv -----
// ---------------------------------------------------------------------------
// acr_dp
// Slot stores, scan trackers, replacement state and the result/output
// registers of the associative cache.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  acr_pkg::t_dp_cmd                 i_cmd,
    output acr_pkg::t_dp_sts                 o_sts,
    input  logic                             i_cfg_valid,
    input  logic [acr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acr_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                             i_kind,
    input  logic [acr_pkg::KEY_W-1:0]        i_key,
    input  logic [acr_pkg::PAY_W-1:0]        i_payload,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_hit,
    output logic [acr_pkg::SLOT_W-1:0]       o_slot,
    output logic [acr_pkg::PAY_W-1:0]        o_read_data,
    output logic                             o_evicted,
    output logic [acr_pkg::KEY_W-1:0]        o_evicted_key
);

    localparam int IDX_W = acr_pkg::IDX_W;

    // slot stores
    logic [acr_pkg::KEY_W-1:0]   mem_key   [acr_pkg::ENTRIES];
    logic [acr_pkg::DATA_W-1:0]  mem_data  [acr_pkg::ENTRIES];
    logic [acr_pkg::STAMP_W-1:0] mem_stamp [acr_pkg::ENTRIES];
    logic [acr_pkg::ENTRIES-1:0] r_valid;

    logic [acr_pkg::KEY_W-1:0]   r_rd_key;
    logic [acr_pkg::DATA_W-1:0]  r_rd_data;
    logic [acr_pkg::STAMP_W-1:0] r_rd_stamp;

    // item and config
    logic                        r_kind;
    logic [acr_pkg::KEY_W-1:0]   r_key;
    logic [acr_pkg::DATA_W-1:0]  r_data;
    logic [acr_pkg::POL_W-1:0]   r_policy;
    logic [acr_pkg::LFSR_W-1:0]  r_lfsr;
    logic [IDX_W-1:0]            r_rr;
    logic [acr_pkg::STAMP_W-1:0] r_item_clk;

    // scan
    logic [IDX_W-1:0]            r_addr;
    logic                        r_chk;
    logic [IDX_W-1:0]            r_chk_idx;
    logic                        r_hit;
    logic [IDX_W-1:0]            r_hit_idx;
    logic                        r_empty;
    logic [IDX_W-1:0]            r_empty_idx;
    logic [acr_pkg::STAMP_W-1:0] r_min_stamp;
    logic [IDX_W-1:0]            r_min_idx;

    // selection and result
    logic                        r_evict;
    logic [IDX_W-1:0]            r_sel;
    logic [IDX_W-1:0]            n_sel;
    logic                        n_evict;
    logic [IDX_W-1:0]            n_victim;
    logic [acr_pkg::LFSR_W-1:0]  lfsr_nxt;
    logic                        chk_valid;

    logic                        r_res_hit;
    logic [acr_pkg::SLOT_W-1:0]  r_res_slot;
    logic [acr_pkg::PAY_W-1:0]   r_res_data;
    logic                        r_res_evicted;
    logic [acr_pkg::KEY_W-1:0]   r_res_evkey;
    logic                        r_out_valid;

    assign lfsr_nxt  = acr_pkg::lfsr_step(r_lfsr);
    assign chk_valid = r_valid[r_chk_idx];

    assign o_sts.scan_last = (r_addr == IDX_W'(acr_pkg::ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // stores: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        r_rd_key   <= mem_key[r_addr];
        r_rd_data  <= mem_data[r_addr];
        r_rd_stamp <= mem_stamp[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (r_kind == acr_pkg::KIND_FILL) begin
                mem_key[r_sel]   <= r_key;
                mem_data[r_sel]  <= r_data;
                mem_stamp[r_sel] <= r_item_clk;
            end else if (r_hit) begin
                mem_stamp[r_sel] <= r_item_clk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.update && r_kind == acr_pkg::KIND_FILL) begin
            r_valid[r_sel] <= 1'b1;
        end
    end

    // configuration and replacement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= acr_pkg::POL_FIFO;
            r_lfsr     <= acr_pkg::LFSR_W'(1);
            r_rr       <= '0;
            r_item_clk <= acr_pkg::STAMP_W'(1);
        end else begin
            if (i_cfg_valid && i_cfg_index == acr_pkg::REG_POLICY) begin
                r_policy <= i_cfg_data[acr_pkg::POL_W-1:0];
            end
            if (i_cfg_valid && i_cfg_index == acr_pkg::REG_SEED) begin
                r_lfsr <= acr_pkg::lfsr_load(i_cfg_data);
            end else if (i_cmd.pick && n_evict && r_policy == acr_pkg::POL_RANDOM) begin
                r_lfsr <= lfsr_nxt;
            end
            if (i_cmd.pick && n_evict && r_policy != acr_pkg::POL_RANDOM &&
                r_policy != acr_pkg::POL_LRU) begin
                r_rr <= (r_rr == IDX_W'(acr_pkg::ENTRIES - 1)) ? '0 : r_rr + 1'b1;
            end
            if (i_cmd.update && r_item_clk != '1) begin
                r_item_clk <= r_item_clk + 1'b1;
            end
        end
    end

    // item capture, scan address and check pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_data <= i_payload[acr_pkg::DATA_W-1:0];
        end
        if (i_cmd.start) begin
            r_addr <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + 1'b1;
        end else if (i_cmd.pick) begin
            r_addr <= n_sel;
        end
        r_chk_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan;
        end
    end

    // trackers: first match, first empty, oldest stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit   <= 1'b0;
            r_empty <= 1'b0;
        end else if (r_chk) begin
            if (chk_valid && r_rd_key == r_key && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!chk_valid && !r_empty) begin
                r_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_chk) begin
            if (chk_valid && r_rd_key == r_key && !r_hit) begin
                r_hit_idx <= r_chk_idx;
            end
            if (!chk_valid && !r_empty) begin
                r_empty_idx <= r_chk_idx;
            end
            // strict compare keeps the lowest index on ties
            if (r_chk_idx == '0 || r_rd_stamp < r_min_stamp) begin
                r_min_stamp <= r_rd_stamp;
                r_min_idx   <= r_chk_idx;
            end
        end
    end

    // slot selection, random victim is the next lfsr value modulo the slot count
    always_comb begin
        case (r_policy)
            acr_pkg::POL_RANDOM: n_victim = IDX_W'(lfsr_nxt % acr_pkg::ENTRIES);
            acr_pkg::POL_LRU:    n_victim = r_min_idx;
            default:             n_victim = r_rr;
        endcase
        n_evict = (r_kind == acr_pkg::KIND_FILL) && !r_empty;
        if (r_kind == acr_pkg::KIND_LOOKUP) begin
            n_sel = r_hit_idx;
        end else if (r_empty) begin
            n_sel = r_empty_idx;
        end else begin
            n_sel = n_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_sel   <= n_sel;
            r_evict <= n_evict;
        end
    end

    // result build and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_hit     <= (r_kind == acr_pkg::KIND_LOOKUP) && r_hit;
            r_res_evicted <= r_evict;
            if (r_kind == acr_pkg::KIND_FILL || r_hit) begin
                r_res_slot <= acr_pkg::SLOT_W'(r_sel);
            end else begin
                r_res_slot <= '0;
            end
            if (r_kind == acr_pkg::KIND_LOOKUP && r_hit) begin
                r_res_data <= acr_pkg::PAY_W'(r_rd_data);
            end else begin
                r_res_data <= '0;
            end
            r_res_evkey <= r_evict ? r_rd_key : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_hit         <= r_res_hit;
            o_slot        <= r_res_slot;
            o_read_data   <= r_res_data;
            o_evicted     <= r_res_evicted;
            o_evicted_key <= r_res_evkey;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/assoc_cache_replacement.sv -----
// ---------------------------------------------------------------------------
// assoc_cache_replacement
// Fully associative cache of message ids with fifo, random or lru eviction.
// ---------------------------------------------------------------------------
// Use: an input word (kind, key, payload) is taken when i_in_valid is high
// and o_in_stall is low. kind 0 looks the key up, kind 1 fills the first
// empty slot or, when all are in use, evicts a victim chosen by the policy
// register. Every input word gives one result word on the output channel,
// taken when o_out_valid is high and i_out_stall is low.
// Timing: the slot stores are scanned one slot per cycle through a single
// registered read port; after the scan the sequencer passes through its
// drain, pick, read-back, update and done states before it returns to idle
// for the next accept; the result is loaded into the output register from done.
// One item is in work at a time; the next is taken while a result still
// sits in the output register, and a stalled receiver holds the block only
// once a second result is ready.
// Config writes (index 0 policy, 1 lfsr seed) are always ready; the user
// must make them while idle, the block itself does not enforce it. Reset
// empties every slot, sets fifo policy and seed one; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module assoc_cache_replacement (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [acr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [acr_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [acr_pkg::KEY_W-1:0]     i_key,
    input  logic [acr_pkg::PAY_W-1:0]     i_payload,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [acr_pkg::SLOT_W-1:0]    o_slot,
    output logic [acr_pkg::PAY_W-1:0]     o_read_data,
    output logic                          o_evicted,
    output logic [acr_pkg::KEY_W-1:0]     o_evicted_key
);

    acr_pkg::t_dp_cmd cmd;
    acr_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    acr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    acr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_slot        (o_slot),
        .o_read_data   (o_read_data),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    // a taken word always puts the sequencer to work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took a word but did not start work");

    // a result only appears at the end of an item in work
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised with no item in work");

    // a lookup never evicts, a fill never hits
    a_hit_xor_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("result marks both hit and eviction");

    // at most one sequencer command per cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.scan, cmd.pick, cmd.update, cmd.load_out}))
        else $error("sequencer issued overlapping commands");

endmodule
